/* design/hnil_pkg.sv */
package hnil_pkg;

   localparam int MAX_ENTRIES      = 1024;
   localparam int ENTRY_AW         = $clog2(MAX_ENTRIES);
   localparam int COUNT_W          = ENTRY_AW + 1;
   localparam int NAME_STORE_BYTES = 16384;
   localparam int NAME_AW          = $clog2(NAME_STORE_BYTES);
   localparam int MAX_NAME_LEN     = 256;
   localparam int QBUF_AW          = $clog2(MAX_NAME_LEN);
   localparam int QLEN_W           = QBUF_AW + 1;
   localparam int OFFSET_BITS      = 48;
   localparam int HASH_W           = 64;

   localparam logic [HASH_W-1:0] FNV_BASIS       = 64'hCBF29CE484222325;
   // prime = 2^40 + 435
   localparam int                FNV_PRIME_SHIFT = 40;
   localparam logic [8:0]        FNV_PRIME_LOW   = 9'd435;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BOUNDS   = 2'd1;
   localparam logic [1:0] ST_ORDER    = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   localparam logic [1:0] CSR_NAME_USED  = 2'd0;
   localparam logic [1:0] CSR_DATA_START = 2'd1;
   localparam logic [1:0] CSR_FILE_LEN   = 2'd2;

   localparam logic KIND_LOAD   = 1'b0;
   localparam logic KIND_LOOKUP = 1'b1;

   typedef struct packed {
      logic [NAME_AW-1:0]     noff;
      logic [8:0]             nlen;
      logic [OFFSET_BITS-1:0] doff;
      logic [OFFSET_BITS-1:0] dsz;
   } entry_type;

   typedef struct packed {
      logic accept;
      logic rd_mid;
      logic cmp_step;
      logic scan_init;
      logic scan_rd;
      logic next_entry;
      logic byte_init;
      logic byte_rd;
      logic byte_next;
      logic respond_found;
      logic respond_miss;
   } cmd_type;

   typedef struct packed {
      logic overflow;
      logic search_open;
      logic scan_end;
      logic hash_eq;
      logic len_eq;
      logic byte_eq;
      logic name_done;
   } stat_type;

endpackage

/* design/hnil_ctrl.sv */
module hnil_ctrl import hnil_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  logic [1:0] op,
   input  logic     last_byte,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     busy
);

   typedef enum logic [2:0] {
      IDLE, SRCH_RD, SRCH_CMP, SCAN_RD, SCAN_CHK, BYTE_RD, BYTE_CMP
   } state_type;

   state_type state_ff, state_in;

   assign busy = (state_ff != IDLE);

   // decode state into datapath commands
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         IDLE: begin
            cmd.accept = start;
            if (start && op == OP_QUERY && last_byte) state_in = SRCH_RD;
         end
         SRCH_RD: begin
            if (stat.overflow) begin
               cmd.respond_miss = 1'b1;
               state_in = IDLE;
            end else if (stat.search_open) begin
               cmd.rd_mid = 1'b1;
               state_in = SRCH_CMP;
            end else begin
               cmd.scan_init = 1'b1;
               state_in = SCAN_RD;
            end
         end
         SRCH_CMP: begin
            cmd.cmp_step = 1'b1;
            state_in = SRCH_RD;
         end
         SCAN_RD: begin
            if (stat.scan_end) begin
               cmd.respond_miss = 1'b1;
               state_in = IDLE;
            end else begin
               cmd.scan_rd = 1'b1;
               state_in = SCAN_CHK;
            end
         end
         SCAN_CHK: begin
            if (!stat.hash_eq) begin
               cmd.respond_miss = 1'b1;
               state_in = IDLE;
            end else if (!stat.len_eq) begin
               cmd.next_entry = 1'b1;
               state_in = SCAN_RD;
            end else begin
               cmd.byte_init = 1'b1;
               state_in = BYTE_RD;
            end
         end
         BYTE_RD: begin
            cmd.byte_rd = 1'b1;
            state_in = BYTE_CMP;
         end
         BYTE_CMP: begin
            if (!stat.byte_eq) begin
               cmd.next_entry = 1'b1;
               state_in = SCAN_RD;
            end else if (stat.name_done) begin
               cmd.respond_found = 1'b1;
               state_in = IDLE;
            end else begin
               cmd.byte_next = 1'b1;
               state_in = BYTE_RD;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   // hold state
   always_ff @(posedge clock) begin
      if (reset) state_ff <= IDLE;
      else       state_ff <= state_in;
   end

   a_one_answer: assert property (@(posedge clock) disable iff (reset)
      !(cmd.respond_found && cmd.respond_miss))
      else $error("found and miss answered together");
   a_answer_idles: assert property (@(posedge clock) disable iff (reset)
      (cmd.respond_found || cmd.respond_miss) |=> !busy)
      else $error("busy after answer");
   a_cmp_after_rd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SRCH_CMP) |-> $past(cmd.rd_mid))
      else $error("search compare without read");
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && op == OP_QUERY && last_byte) |=> busy)
      else $error("final query byte did not start search");

endmodule

/* design/hnil_dp.sv */
module hnil_dp import hnil_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output stat_type               stat,
   input  logic                   csr_valid,
   input  logic [1:0]             csr_index,
   input  logic [OFFSET_BITS-1:0] csr_data,
   input  logic [1:0]             req_op,
   input  logic [HASH_W-1:0]      req_entry_hash,
   input  logic [NAME_AW-1:0]     req_name_offset,
   input  logic [8:0]             req_name_length,
   input  logic [OFFSET_BITS-1:0] req_entry_data_offset,
   input  logic [OFFSET_BITS-1:0] req_entry_data_size,
   input  logic [NAME_AW-1:0]     req_byte_addr,
   input  logic [7:0]             req_byte_value,
   output logic                   rsp_valid,
   output logic                   rsp_kind,
   output logic [1:0]             rsp_load_status,
   output logic                   rsp_found,
   output logic [ENTRY_AW-1:0]    rsp_entry_index,
   output logic [OFFSET_BITS-1:0] rsp_match_data_offset,
   output logic [OFFSET_BITS-1:0] rsp_match_data_size
);

   logic [HASH_W-1:0]      hash_mem [MAX_ENTRIES];
   entry_type              ent_mem  [MAX_ENTRIES];
   logic [7:0]             name_mem [NAME_STORE_BYTES];
   logic [7:0]             qbuf_mem [MAX_NAME_LEN];

   logic [NAME_AW:0]       used_ff;
   logic [OFFSET_BITS-1:0] start_ff, flen_ff;
   logic [COUNT_W-1:0]     count_ff;
   logic [HASH_W-1:0]      last_hash_ff;
   logic [HASH_W-1:0]      run_hash_ff;
   logic [QLEN_W-1:0]      qlen_ff;
   logic                   ovf_ff;
   logic [COUNT_W-1:0]     lo_ff, hi_ff, mid_ff, idx_ff;
   logic [QBUF_AW-1:0]     k_ff;
   logic [HASH_W-1:0]      hash_rd_ff;
   entry_type              ent_rd_ff;
   logic [7:0]             name_rd_ff, q_rd_ff;
   logic                   name_oor_ff;
   logic                   rsp_valid_ff, rsp_kind_ff, rsp_found_ff;
   logic [1:0]             rsp_status_ff;
   logic [ENTRY_AW-1:0]    rsp_index_ff;
   logic [OFFSET_BITS-1:0] rsp_doff_ff, rsp_dsz_ff;

   logic [NAME_AW:0]       bound, name_end, name_addr;
   logic [1:0]             load_st;
   logic [HASH_W-1:0]      hash_x, hash_in;
   logic [COUNT_W-1:0]     mid_in;
   logic                   is_load, is_write, is_query, answer;

   assign is_load  = cmd.accept && req_op == OP_LOAD;
   assign is_write = cmd.accept && req_op == OP_WRITE;
   assign is_query = cmd.accept && req_op == OP_QUERY;
   assign answer   = cmd.respond_found || cmd.respond_miss;

   // load checks
   assign bound    = used_ff[NAME_AW] ? (NAME_AW+1)'(NAME_STORE_BYTES) : used_ff;
   assign name_end = {1'b0, req_name_offset} + (NAME_AW+1)'(req_name_length);
   always_comb begin
      if (count_ff == COUNT_W'(MAX_ENTRIES))
         load_st = ST_FULL;
      else if (name_end > bound || req_entry_data_offset < start_ff ||
               req_entry_data_offset > flen_ff ||
               req_entry_data_size > flen_ff - req_entry_data_offset)
         load_st = ST_BOUNDS;
      else if (count_ff != '0 && last_hash_ff > req_entry_hash)
         load_st = ST_ORDER;
      else
         load_st = ST_OK;
   end

   // FNV-1a step: multiply by 2^40 + 435
   assign hash_x  = run_hash_ff ^ HASH_W'(req_byte_value);
   assign hash_in = (hash_x << FNV_PRIME_SHIFT) + (hash_x * HASH_W'(FNV_PRIME_LOW));

   assign mid_in    = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign name_addr = {1'b0, ent_rd_ff.noff} + (NAME_AW+1)'(k_ff);

   assign stat.overflow    = ovf_ff;
   assign stat.search_open = lo_ff < hi_ff;
   assign stat.scan_end    = idx_ff >= count_ff;
   assign stat.hash_eq     = hash_rd_ff == run_hash_ff;
   assign stat.len_eq      = ent_rd_ff.nlen == qlen_ff;
   assign stat.byte_eq     = (name_oor_ff ? 8'd0 : name_rd_ff) == q_rd_ff;
   assign stat.name_done   = ({1'b0, k_ff} + QLEN_W'(1)) == qlen_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= '0;
         start_ff <= '0;
         flen_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_NAME_USED:  used_ff  <= csr_data[NAME_AW:0];
            CSR_DATA_START: start_ff <= csr_data;
            CSR_FILE_LEN:   flen_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // entry tables
   always_ff @(posedge clock) begin
      if (is_load && load_st == ST_OK) begin
         hash_mem[count_ff[ENTRY_AW-1:0]] <= req_entry_hash;
         ent_mem[count_ff[ENTRY_AW-1:0]]  <= '{req_name_offset, req_name_length,
                                              req_entry_data_offset, req_entry_data_size};
      end
      if (cmd.rd_mid)
         hash_rd_ff <= hash_mem[mid_in[ENTRY_AW-1:0]];
      else if (cmd.scan_rd)
         hash_rd_ff <= hash_mem[idx_ff[ENTRY_AW-1:0]];
      if (cmd.scan_rd)
         ent_rd_ff <= ent_mem[idx_ff[ENTRY_AW-1:0]];
   end

   // name store and query buffer
   always_ff @(posedge clock) begin
      if (is_write) name_mem[req_byte_addr] <= req_byte_value;
      if (is_query && !qlen_ff[QBUF_AW]) qbuf_mem[qlen_ff[QBUF_AW-1:0]] <= req_byte_value;
      if (cmd.byte_rd) begin
         name_rd_ff  <= name_mem[name_addr[NAME_AW-1:0]];
         name_oor_ff <= name_addr[NAME_AW];
         q_rd_ff     <= qbuf_mem[k_ff];
      end
   end

   // control state: count, query accumulation, search pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         run_hash_ff <= FNV_BASIS;
         qlen_ff     <= '0;
         ovf_ff      <= 1'b0;
      end else begin
         if (is_load && load_st == ST_OK) begin
            count_ff     <= count_ff + COUNT_W'(1);
            last_hash_ff <= req_entry_hash;
         end
         if (is_query) begin
            run_hash_ff <= hash_in;
            if (qlen_ff[QBUF_AW]) ovf_ff  <= 1'b1;
            else                  qlen_ff <= qlen_ff + QLEN_W'(1);
         end
         if (answer) begin
            run_hash_ff <= FNV_BASIS;
            qlen_ff     <= '0;
            ovf_ff      <= 1'b0;
         end
      end
      if (is_query) begin
         lo_ff <= '0;
         hi_ff <= count_ff;
      end
      if (cmd.rd_mid) mid_ff <= mid_in;
      if (cmd.cmp_step) begin
         if (hash_rd_ff < run_hash_ff) lo_ff <= mid_ff + COUNT_W'(1);
         else                          hi_ff <= mid_ff;
      end
      if (cmd.scan_init)  idx_ff <= lo_ff;
      if (cmd.next_entry) idx_ff <= idx_ff + COUNT_W'(1);
      if (cmd.byte_init)  k_ff   <= '0;
      if (cmd.byte_next)  k_ff   <= k_ff + QBUF_AW'(1);
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= is_load || answer;
      if (is_load) begin
         rsp_kind_ff   <= KIND_LOAD;
         rsp_status_ff <= load_st;
         rsp_found_ff  <= 1'b0;
         rsp_index_ff  <= '0;
         rsp_doff_ff   <= '0;
         rsp_dsz_ff    <= '0;
      end else if (answer) begin
         rsp_kind_ff   <= KIND_LOOKUP;
         rsp_status_ff <= ST_OK;
         rsp_found_ff  <= cmd.respond_found;
         rsp_index_ff  <= cmd.respond_found ? idx_ff[ENTRY_AW-1:0] : '0;
         rsp_doff_ff   <= cmd.respond_found ? ent_rd_ff.doff : '0;
         rsp_dsz_ff    <= cmd.respond_found ? ent_rd_ff.dsz : '0;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_kind              = rsp_kind_ff;
   assign rsp_load_status       = rsp_status_ff;
   assign rsp_found             = rsp_found_ff;
   assign rsp_entry_index       = rsp_index_ff;
   assign rsp_match_data_offset = rsp_doff_ff;
   assign rsp_match_data_size   = rsp_dsz_ff;

endmodule

/* design/hashed_name_index_lookup.sv */
// Channel   Ports          Transfer rule
// request   start, req_*   taken when start & !busy
// response  rsp_*          rsp_valid high for one cycle, always taken
// config    csr_*          taken when csr_valid & csr_ready (ready always high)
//
// Loads, name byte writes and non-final query bytes leave busy low; a load
// answers in the cycle after it is taken. The final query byte holds busy
// for the search: binary search steps over one hash table read port, then
// a check of each candidate entry and of its name bytes, through single
// read ports on the name store and query buffer. Reset is synchronous,
// active high, and needs no clearing pass. The receiver cannot stall.
module hashed_name_index_lookup import hnil_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_op,
   input  logic [HASH_W-1:0]      req_entry_hash,
   input  logic [NAME_AW-1:0]     req_name_offset,
   input  logic [8:0]             req_name_length,
   input  logic [OFFSET_BITS-1:0] req_entry_data_offset,
   input  logic [OFFSET_BITS-1:0] req_entry_data_size,
   input  logic [NAME_AW-1:0]     req_byte_addr,
   input  logic [7:0]             req_byte_value,
   input  logic                   req_last_byte,
   output logic                   rsp_valid,
   output logic                   rsp_kind,
   output logic [1:0]             rsp_load_status,
   output logic                   rsp_found,
   output logic [ENTRY_AW-1:0]    rsp_entry_index,
   output logic [OFFSET_BITS-1:0] rsp_match_data_offset,
   output logic [OFFSET_BITS-1:0] rsp_match_data_size,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [OFFSET_BITS-1:0] csr_data
);

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   hnil_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .op        (req_op),
      .last_byte (req_last_byte),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy)
   );

   hnil_dp u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .stat                  (stat),
      .csr_valid             (csr_valid),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .req_op                (req_op),
      .req_entry_hash        (req_entry_hash),
      .req_name_offset       (req_name_offset),
      .req_name_length       (req_name_length),
      .req_entry_data_offset (req_entry_data_offset),
      .req_entry_data_size   (req_entry_data_size),
      .req_byte_addr         (req_byte_addr),
      .req_byte_value        (req_byte_value),
      .rsp_valid             (rsp_valid),
      .rsp_kind              (rsp_kind),
      .rsp_load_status       (rsp_load_status),
      .rsp_found             (rsp_found),
      .rsp_entry_index       (rsp_entry_index),
      .rsp_match_data_offset (rsp_match_data_offset),
      .rsp_match_data_size   (rsp_match_data_size)
   );

endmodule

/* test/hashed_name_index_lookup_tb.sv */
`timescale 1ns / 1ps

module hashed_name_index_lookup_tb;
   import hnil_pkg::*;

   localparam logic [63:0] FNV_MULT    = 64'd1099511628211;
   localparam logic [47:0] OFF_ONES    = '1;
   localparam int          EXP_PREDICT = -1;
   localparam int          EXP_MISS    = 4;
   localparam int          NAME_AREA   = 256;

   typedef struct {
      logic [1:0]             op;
      logic [HASH_W-1:0]      hash;
      logic [NAME_AW-1:0]     noff;
      logic [8:0]             nlen;
      logic [OFFSET_BITS-1:0] doff;
      logic [OFFSET_BITS-1:0] dsz;
      logic [NAME_AW-1:0]     addr;
      logic [7:0]             val;
      logic                   last;
   } lookup_req_t;

   typedef struct {
      logic                   kind;
      logic [1:0]             status;
      logic                   found;
      logic [ENTRY_AW-1:0]    idx;
      logic [OFFSET_BITS-1:0] doff;
      logic [OFFSET_BITS-1:0] dsz;
   } answer_t;

   typedef struct {
      logic [HASH_W-1:0] h;
      int                off;
      int                len;
   } name_ref_t;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [1:0]             req_op = '0;
   logic [HASH_W-1:0]      req_entry_hash = '0;
   logic [NAME_AW-1:0]     req_name_offset = '0;
   logic [8:0]             req_name_length = '0;
   logic [OFFSET_BITS-1:0] req_entry_data_offset = '0;
   logic [OFFSET_BITS-1:0] req_entry_data_size = '0;
   logic [NAME_AW-1:0]     req_byte_addr = '0;
   logic [7:0]             req_byte_value = '0;
   logic                   req_last_byte = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_kind;
   logic [1:0]             rsp_load_status;
   logic                   rsp_found;
   logic [ENTRY_AW-1:0]    rsp_entry_index;
   logic [OFFSET_BITS-1:0] rsp_match_data_offset;
   logic [OFFSET_BITS-1:0] rsp_match_data_size;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [1:0]             csr_index = '0;
   logic [OFFSET_BITS-1:0] csr_data = '0;

   // shadow of the index, the name store and the query state
   logic [HASH_W-1:0]      tbl_hash [MAX_ENTRIES];
   int                     tbl_noff [MAX_ENTRIES];
   int                     tbl_nlen [MAX_ENTRIES];
   logic [OFFSET_BITS-1:0] tbl_doff [MAX_ENTRIES];
   logic [OFFSET_BITS-1:0] tbl_dsz  [MAX_ENTRIES];
   logic [7:0]             name_mem [NAME_STORE_BYTES];
   logic [7:0]             qbuf     [MAX_NAME_LEN];
   logic [HASH_W-1:0]      q_hash = FNV_BASIS;
   int                     q_len = 0;
   bit                     q_ovf = 0;
   int                     table_fill = 0;

   // shadow of the registers
   int                     name_used = 0;
   logic [OFFSET_BITS-1:0] data_start = '0;
   logic [OFFSET_BITS-1:0] file_len = '0;

   answer_t                pending_answers[$];
   name_ref_t              name_pool[$];
   name_ref_t              loaded_names[$];
   int                     idle_pct = 0;
   int                     sent = 0;
   bit                     failed = 0;

   always #6 clock = ~clock;

   hashed_name_index_lookup uut (.*);

   function automatic logic [1:0] load_check(lookup_req_t r);
      int bound = (name_used > NAME_STORE_BYTES) ? NAME_STORE_BYTES : name_used;
      if (table_fill >= MAX_ENTRIES) return ST_FULL;
      if (int'(r.noff) + int'(r.nlen) > bound || r.doff < data_start ||
          r.doff > file_len || r.dsz > file_len - r.doff) return ST_BOUNDS;
      if (table_fill > 0 && tbl_hash[table_fill-1] > r.hash) return ST_ORDER;
      return ST_OK;
   endfunction

   // first entry of equal hash by binary search, then scan for an exact name
   function automatic answer_t search_index();
      answer_t a = '{default: '0};
      int lo = 0;
      int hi = table_fill;
      int mid;
      bit same;
      a.kind = KIND_LOOKUP;
      if (q_ovf) return a;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (tbl_hash[mid] < q_hash) lo = mid + 1;
         else hi = mid;
      end
      for (int i = lo; i < table_fill && tbl_hash[i] == q_hash; i++) begin
         same = (tbl_nlen[i] == q_len);
         for (int k = 0; same && k < q_len; k++)
            if (name_mem[tbl_noff[i] + k] != qbuf[k]) same = 0;
         if (same) begin
            a.found = 1'b1;
            a.idx = i[ENTRY_AW-1:0];
            a.doff = tbl_doff[i];
            a.dsz = tbl_dsz[i];
            return a;
         end
      end
      return a;
   endfunction

   // advance the shadow by one transaction and queue what it answers
   function automatic void predict_answer(lookup_req_t r, int exp_code);
      answer_t a = '{default: '0};
      bit emit = 0;
      logic [1:0] st;
      case (r.op)
         OP_LOAD: begin
            st = load_check(r);
            if (st == ST_OK) begin
               tbl_hash[table_fill] = r.hash;
               tbl_noff[table_fill] = int'(r.noff);
               tbl_nlen[table_fill] = int'(r.nlen);
               tbl_doff[table_fill] = r.doff;
               tbl_dsz[table_fill] = r.dsz;
               table_fill++;
            end
            a.kind = KIND_LOAD;
            a.status = st;
            emit = 1;
         end
         OP_WRITE: name_mem[r.addr] = r.val;
         OP_QUERY: begin
            q_hash = (q_hash ^ {56'd0, r.val}) * FNV_MULT;
            if (q_len < MAX_NAME_LEN) begin
               qbuf[q_len] = r.val;
               q_len++;
            end else begin
               q_ovf = 1;
            end
            if (r.last) begin
               a = search_index();
               emit = 1;
               q_hash = FNV_BASIS;
               q_len = 0;
               q_ovf = 0;
            end
         end
         default: ;
      endcase
      if (exp_code == EXP_MISS) begin
         a = '{default: '0};
         a.kind = KIND_LOOKUP;
      end else if (exp_code != EXP_PREDICT) begin
         a = '{default: '0};
         a.kind = KIND_LOAD;
         a.status = exp_code[1:0];
      end
      if (emit) pending_answers.push_back(a);
   endfunction

   function automatic logic [HASH_W-1:0] name_hash(int off, int len);
      logic [HASH_W-1:0] h = FNV_BASIS;
      for (int k = 0; k < len; k++) h = (h ^ {56'd0, name_mem[off + k]}) * FNV_MULT;
      return h;
   endfunction

   function automatic logic [63:0] rand_upto(logic [63:0] n);
      return {$urandom, $urandom} % (n + 1);
   endfunction

   function automatic lookup_req_t mk_load(logic [63:0] h, int noff, int nlen,
                                           logic [47:0] doff, logic [47:0] dsz);
      lookup_req_t r = '{default: '0};
      r.op = OP_LOAD;
      r.hash = h;
      r.noff = noff[NAME_AW-1:0];
      r.nlen = nlen[8:0];
      r.doff = doff;
      r.dsz = dsz;
      return r;
   endfunction

   function automatic lookup_req_t mk_byte(logic [1:0] op, int addr, logic [7:0] val,
                                           logic last);
      lookup_req_t r = '{default: '0};
      r.op = op;
      r.addr = addr[NAME_AW-1:0];
      r.val = val;
      r.last = last;
      return r;
   endfunction

   // pick data within the current legal window, or an illegal one if none exists
   function automatic lookup_req_t legal_load(logic [63:0] h, int noff, int nlen);
      logic [47:0] doff = file_len;
      logic [47:0] dsz = '0;
      if (data_start <= file_len) begin
         doff = data_start + 48'(rand_upto(64'(file_len - data_start)));
         dsz = 48'(rand_upto(64'(file_len - doff)));
      end
      return mk_load(h, noff, nlen, doff, dsz);
   endfunction

   // hold the transaction until start meets an idle block
   task automatic drive_req(lookup_req_t r, int exp_code = EXP_PREDICT);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      req_op <= r.op;
      req_entry_hash <= r.hash;
      req_name_offset <= r.noff;
      req_name_length <= r.nlen;
      req_entry_data_offset <= r.doff;
      req_entry_data_size <= r.dsz;
      req_byte_addr <= r.addr;
      req_byte_value <= r.val;
      req_last_byte <= r.last;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      predict_answer(r, exp_code);
      sent++;
   endtask

   task automatic send_query_bytes(int len, int off, bit from_store);
      logic [7:0] v;
      for (int k = 0; k < len; k++) begin
         v = from_store ? name_mem[off + k] : 8'($urandom);
         drive_req(mk_byte(OP_QUERY, 0, v, k == len - 1));
      end
   endtask

   // drain all answers, then leave room for an unanswered write to finish
   task automatic settle();
      start <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [47:0] value);
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_NAME_USED:  name_used = int'(value[14:0]);
         CSR_DATA_START: data_start = value;
         CSR_FILE_LEN:   file_len = value;
         default: ;
      endcase
   endtask

   task automatic set_config(int used, logic [47:0] dstart, logic [47:0] flen);
      settle();
      write_csr(CSR_NAME_USED, 48'(used));
      write_csr(CSR_DATA_START, dstart);
      write_csr(CSR_FILE_LEN, flen);
   endtask

   // sorted pool of names from the written area, loaded in hash order
   task automatic build_pool(int n);
      name_ref_t e;
      int pos;
      for (int i = 0; i < n; i++) begin
         e.len = ($urandom_range(19) == 0) ? $urandom_range(13, 48)
                                           : $urandom_range(1, 12);
         e.off = $urandom_range(0, NAME_AREA - e.len);
         e.h = name_hash(e.off, e.len);
         pos = 0;
         while (pos < name_pool.size() && name_pool[pos].h < e.h) pos++;
         name_pool.insert(pos, e);
      end
   endtask

   task automatic random_phase(int target);
      lookup_req_t r;
      name_ref_t e;
      int pick;
      int cnt0;
      int len;
      int stop = sent + target;
      while (sent < stop) begin
         pick = $urandom_range(99);
         if (pick < 30 && name_pool.size() != 0) begin
            e = name_pool.pop_front();
            // an alias with the same hash but another name forces a longer scan
            if ($urandom_range(7) == 0) begin
               len = $urandom_range(1, 12);
               drive_req(legal_load(e.h, $urandom_range(0, NAME_AREA - len), len));
            end
            cnt0 = table_fill;
            drive_req(legal_load(e.h, e.off, e.len));
            if (table_fill != cnt0) loaded_names.push_back(e);
         end else if (pick < 45) begin
            r = mk_load({$urandom, $urandom}, $urandom, $urandom,
                        48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
            // keep noise from raising the hash floor of the table
            if (load_check(r) == ST_OK && table_fill > 0)
               r.hash = (tbl_hash[table_fill-1] == '0) ? '0
                                                       : rand_upto(tbl_hash[table_fill-1] - 1);
            drive_req(r);
         end else if (pick < 55) begin
            drive_req(mk_byte(OP_WRITE, $urandom, 8'($urandom), 1'($urandom)));
         end else if (pick < 60) begin
            r = mk_load({$urandom, $urandom}, $urandom, $urandom,
                        48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
            r.op = 2'd3;
            r.addr = 14'($urandom);
            r.val = 8'($urandom);
            r.last = 1'($urandom);
            drive_req(r);
         end else if (pick < 85 && loaded_names.size() != 0) begin
            e = loaded_names[$urandom_range(0, loaded_names.size() - 1)];
            send_query_bytes(e.len, e.off, 1);
         end else begin
            send_query_bytes($urandom_range(1, 6), 0, 0);
         end
      end
   endtask

   // check each answer against the oldest expectation
   always @(posedge clock) begin
      answer_t x;
      if (!reset && rsp_valid) begin
         if (pending_answers.size() == 0) begin
            $error("answer with nothing expected: kind %0d", rsp_kind);
            failed = 1;
         end else begin
            x = pending_answers.pop_front();
            if (rsp_kind !== x.kind) begin
               $error("kind: expected %0d, got %0d", x.kind, rsp_kind);
               failed = 1;
            end
            if (rsp_load_status !== x.status) begin
               $error("load_status: expected %0d, got %0d", x.status, rsp_load_status);
               failed = 1;
            end
            if (rsp_found !== x.found) begin
               $error("found: expected %0d, got %0d", x.found, rsp_found);
               failed = 1;
            end
            if (rsp_entry_index !== x.idx) begin
               $error("entry_index: expected %0d, got %0d", x.idx, rsp_entry_index);
               failed = 1;
            end
            if (rsp_match_data_offset !== x.doff) begin
               $error("match_data_offset: expected %h, got %h", x.doff,
                      rsp_match_data_offset);
               failed = 1;
            end
            if (rsp_match_data_size !== x.dsz) begin
               $error("match_data_size: expected %h, got %h", x.dsz, rsp_match_data_size);
               failed = 1;
            end
         end
      end
   end

   initial begin
      #10ms;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      lookup_req_t dir_req[$];
      int          dir_exp[$];

      for (int i = 0; i < NAME_STORE_BYTES; i++) name_mem[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_config(NAME_AREA, 48'd16, 48'd1000);

      // fill the name area the lookups compare against
      for (int i = 0; i < NAME_AREA; i++) drive_req(mk_byte(OP_WRITE, i, 8'($urandom), 1'b0));

      // directed: bounds edges, order, ignored op, name store edge, zero byte
      dir_req.push_back(mk_load(64'd0, 0, 0, 48'd16, 48'd0));     dir_exp.push_back(ST_OK);
      dir_req.push_back(mk_load(64'd1, 253, 3, 48'd1000, 48'd0)); dir_exp.push_back(ST_OK);
      dir_req.push_back(mk_load(64'd1, 254, 3, 48'd16, 48'd0));   dir_exp.push_back(ST_BOUNDS);
      dir_req.push_back(mk_load(64'd1, 0, 3, 48'd15, 48'd0));     dir_exp.push_back(ST_BOUNDS);
      dir_req.push_back(mk_load(64'd1, 0, 3, 48'd1001, 48'd0));   dir_exp.push_back(ST_BOUNDS);
      dir_req.push_back(mk_load(64'd1, 0, 3, 48'd999, 48'd2));    dir_exp.push_back(ST_BOUNDS);
      dir_req.push_back(mk_load(64'd0, 0, 3, 48'd20, 48'd5));     dir_exp.push_back(ST_ORDER);
      dir_req.push_back(mk_load(64'd2, 0, 256, 48'd16, 48'd984)); dir_exp.push_back(ST_OK);
      dir_req.push_back(mk_byte(2'd3, 0, 8'hFF, 1'b1));           dir_exp.push_back(EXP_PREDICT);
      dir_req.push_back(mk_byte(OP_WRITE, 16383, 8'hFF, 1'b1));   dir_exp.push_back(EXP_PREDICT);
      dir_req.push_back(mk_byte(OP_QUERY, 0, 8'h00, 1'b1));       dir_exp.push_back(EXP_MISS);
      dir_req.push_back(mk_byte(OP_QUERY, 0, 8'hFF, 1'b0));       dir_exp.push_back(EXP_PREDICT);
      dir_req.push_back(mk_byte(OP_QUERY, 0, 8'h80, 1'b1));       dir_exp.push_back(EXP_PREDICT);
      foreach (dir_req[i]) drive_req(dir_req[i], dir_exp[i]);

      // query an overlong name: still hashed, never found
      send_query_bytes(MAX_NAME_LEN + 1, 0, 0);

      build_pool(40);
      set_config(NAME_STORE_BYTES, 48'd0, OFF_ONES);
      idle_pct = 0;
      random_phase(30);
      set_config(32767, 48'h1000, 48'h0000_FFFF_FFFF);
      idle_pct = 70;
      random_phase(30);
      set_config(0, OFF_ONES, OFF_ONES);
      idle_pct = 0;
      random_phase(25);
      set_config(600, 48'd0, 48'd0);
      idle_pct = 35;
      random_phase(25);

      if (loaded_names.size() != 0)
         send_query_bytes(loaded_names[0].len, loaded_names[0].off, 1);
      send_query_bytes(2, 0, 0);

      settle();
      repeat (20) @(posedge clock);
      if (!failed) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
